// ----- rtl/wfd_pkg.sv -----
// Shared types, widths and constants for the wall-follow PD motor drive.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package wfd_pkg;

  localparam int SAMPLES_PER_AVERAGE = 5;
  localparam int SPEED_LIMIT         = 1023;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 13;
  localparam int CNT_W    = 3;
  localparam int ERR_W    = 11;
  localparam int DIFF_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 10;
  localparam int CORR_W   = 16;
  localparam int CORR_MAX = 32767;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Division by the sample count is a multiply by a rounded-up reciprocal.
  // With a 17-bit shift the result is exact for every 13-bit sum.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = (2 ** RECIP_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QUOT_W      = SUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_SIDE  = 2'd0,
    CFG_PROP_GAIN  = 2'd1,
    CFG_DIFF_GAIN  = 2'd2,
    CFG_BASE_SPEED = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                wall_side;
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   diff_gain;
    logic [SPEED_W-1:0]  base_speed;
  } cfg_t;

  // One queued request: the error terms of one finished average.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
  } pd_term_t;

endpackage

`default_nettype wire

// ----- rtl/wfd_if.sv -----
// Valid/ready channel interfaces for sensor samples and motor commands.
// Depends on wfd_pkg for field widths.
`default_nettype none

interface wfd_in_if import wfd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface wfd_out_if import wfd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [SPEED_W-1:0]       motor_a_duty;
  logic                     motor_a_reverse;
  logic [SPEED_W-1:0]       motor_b_duty;
  logic                     motor_b_reverse;
  logic signed [CORR_W-1:0] correction;

  modport source (output valid, output motor_a_duty, output motor_a_reverse,
                  output motor_b_duty, output motor_b_reverse, output correction,
                  input ready);
  modport sink   (input valid, input motor_a_duty, input motor_a_reverse,
                  input motor_b_duty, input motor_b_reverse, input correction,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/wall_follow_pd_motor_drive.sv -----
// Wall-follow PD motor drive. Takes one sample pair per cycle while in_ch.ready
// is high (it drops when the queue has no space left); every SAMPLES_PER_AVERAGE
// accepted samples give one motor command, which passes the sum register, request
// queue, product stage, correction stage and output register before it is valid.
// Synchronous active-low reset restores register defaults and clears the
// averager, set point and queue; no clearing pass is needed.
`default_nettype none

module wall_follow_pd_motor_drive import wfd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  wfd_in_if.sink                    in_ch,
  wfd_out_if.source                 out_ch,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  logic              push;
  pd_term_t          push_data;
  logic              pop;
  logic              rd_valid;
  pd_term_t          rd_data;
  logic [QCNT_W-1:0] q_count;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WALL_SIDE:  cfg_nxt.wall_side  = cfg_wdata[0];
        CFG_PROP_GAIN:  cfg_nxt.prop_gain  = cfg_wdata[GAIN_W-1:0];
        CFG_DIFF_GAIN:  cfg_nxt.diff_gain  = cfg_wdata[GAIN_W-1:0];
        CFG_BASE_SPEED: cfg_nxt.base_speed = cfg_wdata[SPEED_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wall_side  <= 1'b0;
      cfg_r.prop_gain  <= GAIN_W'(205);
      cfg_r.diff_gain  <= GAIN_W'(2560);
      cfg_r.base_speed <= SPEED_W'(750);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wall_side (cfg_r.wall_side),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  wfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_valid  (rd_valid),
    .rd_data   (rd_data),
    .q_count   (q_count)
  );

  wfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/wfd_front.sv -----
// Front end: sample selection, averaging, set point capture and error terms.
// Depends on wfd_pkg and wfd_in_if; pushes one request per average.
`default_nettype none

module wfd_front import wfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  wfd_in_if.sink                 in_ch,
  input  wire logic              wall_side,
  input  wire logic [QCNT_W-1:0] q_count,
  output logic                   push,
  output pd_term_t               push_data
);

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    fin_sum_r, fin_sum_nxt;
  logic                fin_vld_r, fin_vld_nxt;
  logic [SAMPLE_W-1:0] target_r, target_nxt;
  logic                captured_r, captured_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;

  logic                accept;
  logic [SAMPLE_W-1:0] sample;
  logic [SUM_W-1:0]    sum_add;
  logic                last;
  logic [QUOT_W-1:0]   quot_full;
  logic [QUOT_W-RECIP_SHIFT-1:0] quot;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] tgt;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;

  // The finished sum still in flight counts against the queue space.
  assign in_ch.ready = ({1'b0, q_count} + (QCNT_W + 1)'(fin_vld_r))
                       < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign sample  = wall_side ? in_ch.left_sample : in_ch.right_sample;
  assign sum_add = sum_r + SUM_W'(sample);
  assign last    = ({1'b0, count_r} + (CNT_W + 1)'(1))
                   >= (CNT_W + 1)'(SAMPLES_PER_AVERAGE);

  assign quot_full = QUOT_W'(fin_sum_r) * QUOT_W'(RECIP);
  assign quot      = quot_full[QUOT_W-1:RECIP_SHIFT];
  assign avg       = (quot > (QUOT_W - RECIP_SHIFT)'(2 ** SAMPLE_W - 1)) ?
                     {SAMPLE_W{1'b1}} : quot[SAMPLE_W-1:0];

  assign tgt  = captured_r ? target_r : avg;
  assign err  = $signed({1'b0, tgt}) - $signed({1'b0, avg});
  assign diff = DIFF_W'(err) - DIFF_W'(prev_err_r);

  assign push           = fin_vld_r;
  assign push_data.err  = err;
  assign push_data.diff = diff;

  always_comb begin
    sum_nxt      = sum_r;
    count_nxt    = count_r;
    fin_sum_nxt  = fin_sum_r;
    fin_vld_nxt  = 1'b0;
    target_nxt   = target_r;
    captured_nxt = captured_r;
    prev_err_nxt = prev_err_r;
    if (accept) begin
      if (last) begin
        fin_sum_nxt = sum_add;
        fin_vld_nxt = 1'b1;
        sum_nxt     = '0;
        count_nxt   = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (fin_vld_r) begin
      target_nxt   = tgt;
      captured_nxt = 1'b1;
      prev_err_nxt = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      count_r    <= '0;
      fin_vld_r  <= 1'b0;
      target_r   <= '0;
      captured_r <= 1'b0;
      prev_err_r <= '0;
    end else begin
      sum_r      <= sum_nxt;
      count_r    <= count_nxt;
      fin_vld_r  <= fin_vld_nxt;
      target_r   <= target_nxt;
      captured_r <= captured_nxt;
      prev_err_r <= prev_err_nxt;
    end
    fin_sum_r <= fin_sum_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/wfd_queue.sv -----
// Short request queue between the front end and the PD back end.
// Depends on wfd_pkg for the request type and depth.
`default_nettype none

module wfd_queue import wfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pd_term_t          push_data,
  input  wire logic              pop,
  output logic                   rd_valid,
  output pd_term_t               rd_data,
  output logic [QCNT_W-1:0]      q_count
);

  pd_term_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign q_count  = count_r;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wfd_back.sv -----
// Back end: PD products, scaling and saturation, motor speed split.
// Depends on wfd_pkg and wfd_out_if; three stages that stall from the output.
`default_nettype none

module wfd_back import wfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     rd_valid,
  input  wire pd_term_t rd_data,
  output logic          pop,
  wfd_out_if.source     out_ch
);

  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int PD_W  = GAIN_W + 1 + DIFF_W;
  localparam int TOT_W = PD_W + 1;
  localparam int SPD_W = CORR_W + 2;

  logic                    v1_r, v2_r, v3_r;
  logic                    v1_nxt, v2_nxt, v3_nxt;
  logic signed [PP_W-1:0]  p_r, p_nxt;
  logic signed [PD_W-1:0]  d_r, d_nxt;
  logic signed [CORR_W-1:0] corr_r, corr_nxt;
  logic [SPEED_W-1:0]      a_duty_r, b_duty_r;
  logic                    a_rev_r, b_rev_r;
  logic signed [CORR_W-1:0] out_corr_r;

  logic                    adv1, adv2, adv3;
  logic signed [TOT_W-1:0] total;
  logic [TOT_W-1:0]        mag;
  logic [TOT_W-9:0]        scaled;
  logic [CORR_W-1:0]       sat;
  logic signed [SPD_W-1:0] base_s, corr_s, speed_a, speed_b;
  logic [SPEED_W:0]        drv_a, drv_b;

  // Clamps a signed speed and returns {reverse, duty}.
  function automatic logic [SPEED_W:0] drive(input logic signed [SPD_W-1:0] s);
    logic signed [SPD_W-1:0] c;
    logic signed [SPD_W-1:0] m;
    c = s;
    if (s > $signed(SPD_W'(SPEED_LIMIT))) begin
      c = $signed(SPD_W'(SPEED_LIMIT));
    end else if (s < -$signed(SPD_W'(SPEED_LIMIT))) begin
      c = -$signed(SPD_W'(SPEED_LIMIT));
    end
    m = (c < 0) ? -c : c;
    return {c < 0, m[SPEED_W-1:0]};
  endfunction

  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign pop  = adv1;

  assign p_nxt = PP_W'($signed({1'b0, cfg.prop_gain})) * PP_W'(rd_data.err);
  assign d_nxt = PD_W'($signed({1'b0, cfg.diff_gain})) * PD_W'(rd_data.diff);

  // Scale by 1/256 with truncation toward zero, then saturate the magnitude.
  assign total  = TOT_W'(p_r) + TOT_W'(d_r);
  assign mag    = (total < 0) ? TOT_W'(-total) : TOT_W'(total);
  assign scaled = mag[TOT_W-1:8];
  assign sat    = (scaled > (TOT_W - 8)'(CORR_MAX)) ? CORR_W'(CORR_MAX) :
                  scaled[CORR_W-1:0];
  assign corr_nxt = (total < 0) ? -$signed(sat) : $signed(sat);

  assign base_s  = $signed(SPD_W'(cfg.base_speed));
  assign corr_s  = SPD_W'(corr_r);
  assign speed_a = cfg.wall_side ? base_s + corr_s : base_s - corr_s;
  assign speed_b = cfg.wall_side ? base_s - corr_s : base_s + corr_s;
  assign drv_a   = drive(speed_a);
  assign drv_b   = drive(speed_b);

  always_comb begin
    v1_nxt = adv1 ? rd_valid : v1_r;
    v2_nxt = adv2 ? v1_r : v2_r;
    v3_nxt = adv3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
    if (adv1) begin
      p_r <= p_nxt;
      d_r <= d_nxt;
    end
    if (adv2) begin
      corr_r <= corr_nxt;
    end
    if (adv3) begin
      a_rev_r    <= drv_a[SPEED_W];
      a_duty_r   <= drv_a[SPEED_W-1:0];
      b_rev_r    <= drv_b[SPEED_W];
      b_duty_r   <= drv_b[SPEED_W-1:0];
      out_corr_r <= corr_r;
    end
  end

  assign out_ch.valid           = v3_r;
  assign out_ch.motor_a_duty    = a_duty_r;
  assign out_ch.motor_a_reverse = a_rev_r;
  assign out_ch.motor_b_duty    = b_duty_r;
  assign out_ch.motor_b_reverse = b_rev_r;
  assign out_ch.correction      = out_corr_r;

endmodule

`default_nettype wire
